>>> design/itd_pkg.sv
// ---------------------------------------------------------------------------
// itd_pkg: shared types and constants for the radix digit expander
// Widths, base limits, ASCII mapping and the sequencer state type.
// ---------------------------------------------------------------------------
package itd_pkg;

  localparam int unsigned VALUE_BITS_DEF = 32;
  localparam int unsigned IN_W           = 32;
  localparam int unsigned BASE_W         = 6;
  localparam int unsigned CHAR_W         = 7;
  localparam int unsigned POS_W          = 5;

  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_GAP  = 7'd7;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_OUT  = 3'b100
  } state_t;

  // Clamp the programmed base into the supported 2..36 range.
  function automatic logic [BASE_W-1:0] eff_base(input logic [BASE_W-1:0] b);
    logic [BASE_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // '0'-'9' then 'A'-'Z'.
  function automatic logic [CHAR_W-1:0] char_of(input logic [BASE_W-1:0] d);
    logic [CHAR_W-1:0] c;
    c = {1'b0, d} + CHAR_ZERO;
    if (c > CHAR_NINE) c = c + CHAR_GAP;
    return c;
  endfunction

endpackage

>>> design/itd_if.sv
// ---------------------------------------------------------------------------
// itd channel interfaces
// Valid/ready channels for input values, digit results and base writes.
// ---------------------------------------------------------------------------
interface itd_in_if;
  logic                        valid;
  logic                        ready;
  logic [itd_pkg::IN_W-1:0]    value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itd_out_if;
  logic                        valid;
  logic                        ready;
  logic [itd_pkg::BASE_W-1:0]  digit;
  logic [itd_pkg::CHAR_W-1:0]  digit_char;
  logic [itd_pkg::POS_W-1:0]   position;
  logic                        last;
  modport source (output valid, output digit, output digit_char, output position,
                  output last, input ready);
  modport sink   (input valid, input digit, input digit_char, input position,
                  input last, output ready);
endinterface

interface itd_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [itd_pkg::BASE_W-1:0]  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> design/itd_div.sv
// ---------------------------------------------------------------------------
// itd_div: bit-serial restoring divider
// Divides a VALUE_BITS dividend by a 6-bit divisor, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module itd_div #(
  parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [VALUE_BITS-1:0]       dividend,
  input  logic [itd_pkg::BASE_W-1:0]  divisor,
  output logic                        busy,
  output logic                        done,
  output logic [VALUE_BITS-1:0]       quotient,
  output logic [itd_pkg::BASE_W-1:0]  remainder
);

  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0]        quo_r, quo_nxt;
  logic [itd_pkg::BASE_W-1:0]   rem_r, rem_nxt;
  logic [itd_pkg::BASE_W-1:0]   dsr_r, dsr_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic [itd_pkg::BASE_W:0]     trial;
  logic                         fits;

  assign trial = {rem_r, quo_r[VALUE_BITS-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // shift one dividend bit into the partial remainder, subtract if it fits
      if (fits) rem_nxt = itd_pkg::BASE_W'(trial - {1'b0, dsr_r});
      else      rem_nxt = trial[itd_pkg::BASE_W-1:0];
      quo_nxt = {quo_r[VALUE_BITS-2:0], fits};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

>>> design/integer_to_radix_digits.sv
// ---------------------------------------------------------------------------
// integer_to_radix_digits: unsigned integer to base-N digit stream
// Expands each input value into its digits, least significant first.
// ---------------------------------------------------------------------------
// Usage:
//   in_chan  : one request per value (32 bits, low VALUE_BITS used).
//   out_chan : one request per digit with its value, ASCII character,
//              position (wraps modulo 32) and a last flag on the top digit.
//   cfg_chan : writes the base register (reset 10); 0 and 1 act as 2,
//              37 and up act as 36. Always ready; write only while idle.
// Sequence:
//   Each digit comes from one pass of the shared bit-serial divider,
//   which starts when the value or the previous digit is accepted; its
//   registered done strobe moves the sequencer to ST_OUT to present it.
//   A value of zero produces no digits; in_chan is ready again next cycle.
//   in_chan is not ready while an item is in flight.
// Reset: synchronous, active low; returns to idle and restores base 10.
// Stall: a digit holds on out_chan until taken; the next division starts
//   only after that.
// ---------------------------------------------------------------------------
module integer_to_radix_digits #(
  parameter int unsigned VALUE_BITS = itd_pkg::VALUE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  itd_in_if.sink      in_chan,
  itd_out_if.source   out_chan,
  itd_cfg_if.sink     cfg_chan
);

  itd_pkg::state_t              state_r, state_nxt;
  logic [itd_pkg::BASE_W-1:0]   base_r, base_nxt;
  logic [itd_pkg::BASE_W-1:0]   beff_r, beff_nxt;
  logic [itd_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [VALUE_BITS-1:0]        in_val;
  logic                         in_acc;
  logic                         out_acc;
  logic                         div_start;
  logic [VALUE_BITS-1:0]        div_dividend;
  logic                         div_busy;
  logic                         div_done;
  logic [VALUE_BITS-1:0]        div_quo;
  logic [itd_pkg::BASE_W-1:0]   div_rem;

  generate
    if (VALUE_BITS <= itd_pkg::IN_W) begin : g_narrow
      assign in_val = in_chan.value[VALUE_BITS-1:0];
    end else begin : g_wide
      assign in_val = {{(VALUE_BITS - itd_pkg::IN_W){1'b0}}, in_chan.value};
    end
  endgenerate

  assign in_chan.ready  = (state_r == itd_pkg::ST_IDLE);
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  // start on a nonzero value, or continue with the held quotient
  assign div_start    = (in_acc && (in_val != '0)) ||
                        (out_acc && !out_chan.last);
  assign div_dividend = (state_r == itd_pkg::ST_IDLE) ? in_val : div_quo;

  itd_div #(.VALUE_BITS(VALUE_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (beff_nxt),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    beff_nxt  = beff_r;
    pos_nxt   = pos_r;
    if (cfg_chan.valid && cfg_chan.ready) base_nxt = cfg_chan.data;
    case (state_r)
      itd_pkg::ST_IDLE: begin
        if (in_acc) begin
          beff_nxt = itd_pkg::eff_base(base_r);
          pos_nxt  = '0;
          if (in_val != '0) state_nxt = itd_pkg::ST_DIV;
        end
      end
      itd_pkg::ST_DIV: begin
        if (div_done) state_nxt = itd_pkg::ST_OUT;
      end
      itd_pkg::ST_OUT: begin
        if (out_acc) begin
          pos_nxt = pos_r + 1'b1;
          if (out_chan.last) state_nxt = itd_pkg::ST_IDLE;
          else               state_nxt = itd_pkg::ST_DIV;
        end
      end
      default: state_nxt = itd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itd_pkg::ST_IDLE;
      base_r  <= itd_pkg::BASE_RESET;
      beff_r  <= itd_pkg::BASE_RESET;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      beff_r  <= beff_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // divider holds quotient and remainder until the next start
  assign out_chan.valid      = (state_r == itd_pkg::ST_OUT);
  assign out_chan.digit      = div_rem;
  assign out_chan.digit_char = itd_pkg::char_of(div_rem);
  assign out_chan.position   = pos_r;
  assign out_chan.last       = (div_quo == '0);

  a_out_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !div_busy)
    else $error("digit presented while divider still running");

  a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.digit < beff_r))
    else $error("digit not below the active base");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == itd_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_out_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_chan.valid) |-> $past(div_done))
    else $error("digit presented without a completed division");

endmodule

>>> test/tb.sv
// ---------------------------------------------------------------------------
// tb: testbench for integer_to_radix_digits
// Sends values and base writes to the digit expander. It predicts each
// value's digit sequence and checks every digit request field by field,
// with random idle gaps on both channels and one long receiver hold-off.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import itd_pkg::*;

  localparam int DIGIT_CYCLES = VALUE_BITS_DEF + 2;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 5000;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 34;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 24;

  typedef struct packed {
    logic [BASE_W-1:0] digit;
    logic [CHAR_W-1:0] digit_char;
    logic [POS_W-1:0]  position;
    logic              last;
  } digit_rec_t;

  // One directed request. Rows marked typed carry their digit here (zero or
  // one digit); the rest go through the digit predictor.
  typedef struct {
    logic [BASE_W-1:0] base;
    logic [IN_W-1:0]   value;
    bit                typed;
    int                n_digits;
    logic [BASE_W-1:0] digit;
    logic [CHAR_W-1:0] digit_char;
  } dir_row_t;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{6'd10, 32'd0,          1'b1, 0, 6'd0,  7'd0},
    '{6'd10, 32'd1,          1'b1, 1, 6'd1,  7'd49},
    '{6'd10, 32'd9,          1'b1, 1, 6'd9,  7'd57},
    '{6'd10, 32'hFFFF_FFFF,  1'b0, 0, 6'd0,  7'd0},
    '{6'd10, 32'd10,         1'b0, 0, 6'd0,  7'd0},
    '{6'd10, 32'd1000000000, 1'b0, 0, 6'd0,  7'd0},
    '{6'd10, 32'h8000_0000,  1'b0, 0, 6'd0,  7'd0},
    '{6'd36, 32'd35,         1'b1, 1, 6'd35, 7'd90},
    '{6'd36, 32'd10,         1'b1, 1, 6'd10, 7'd65},
    '{6'd36, 32'hFFFF_FFFF,  1'b0, 0, 6'd0,  7'd0},
    '{6'd36, 32'd36,         1'b0, 0, 6'd0,  7'd0},
    '{6'd2,  32'd1,          1'b1, 1, 6'd1,  7'd49},
    '{6'd2,  32'hFFFF_FFFF,  1'b0, 0, 6'd0,  7'd0},
    '{6'd2,  32'h8000_0000,  1'b0, 0, 6'd0,  7'd0},
    '{6'd2,  32'd0,          1'b1, 0, 6'd0,  7'd0},
    '{6'd0,  32'hAAAA_AAAA,  1'b0, 0, 6'd0,  7'd0},
    '{6'd0,  32'd1,          1'b1, 1, 6'd1,  7'd49},
    '{6'd1,  32'd5,          1'b0, 0, 6'd0,  7'd0},
    '{6'd37, 32'd35,         1'b1, 1, 6'd35, 7'd90},
    '{6'd63, 32'h5555_5555,  1'b0, 0, 6'd0,  7'd0},
    '{6'd63, 32'd0,          1'b1, 0, 6'd0,  7'd0},
    '{6'd16, 32'hDEAD_BEEF,  1'b0, 0, 6'd0,  7'd0},
    '{6'd16, 32'd15,         1'b1, 1, 6'd15, 7'd70},
    '{6'd16, 32'h7FFF_FFFF,  1'b0, 0, 6'd0,  7'd0}
  };

  logic [BASE_W-1:0] phase_bases [10] = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd0,
                                          6'd1, 6'd37, 6'd63, 6'd8, 6'd3};

  logic clk;
  logic rst_n;

  itd_in_if  in_if ();
  itd_out_if out_if ();
  itd_cfg_if cfg_if ();

  integer_to_radix_digits DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_chan (cfg_if)
  );

  digit_rec_t        digits_q [$];
  logic [BASE_W-1:0] cur_base;
  int                errors = 0;
  int                idle_cycles = 0;
  int                out_gap = 0;
  bit                quiet = 1'b0;
  bit                hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
    if (b < BASE_MIN) return BASE_MIN;
    if (b > BASE_MAX) return BASE_MAX;
    return b;
  endfunction

  // Divide down until the quotient is zero; one expected digit per remainder.
  task automatic predict_digits(input logic [IN_W-1:0] v);
    logic [IN_W-1:0]   q;
    logic [BASE_W-1:0] b;
    logic [CHAR_W-1:0] c;
    logic [POS_W-1:0]  pos;
    digit_rec_t        rec;
    q   = v;
    b   = clamp_base(cur_base);
    pos = '0;
    while (q != 0) begin
      rec.digit = BASE_W'(q % b);
      q = q / b;
      c = CHAR_ZERO + CHAR_W'(rec.digit);
      if (c > CHAR_NINE) c = c + CHAR_GAP;
      rec.digit_char = c;
      rec.position   = pos;
      rec.last       = (q == 0);
      digits_q.push_back(rec);
      pos++;
    end
  endtask

  function automatic logic [IN_W-1:0] rand_value();
    logic [63:0]       p;
    logic [BASE_W-1:0] b;
    int                r;
    int                k;
    b = clamp_base(cur_base);
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    if (r < 60) return $urandom >> $urandom_range(0, 31);
    if (r < 78) begin
      // a power of the base, or one either side of it
      p = 64'd1;
      k = $urandom_range(1, 32);
      repeat (k) if (p * b <= 64'hFFFF_FFFF) p = p * b;
      return IN_W'(p + $urandom_range(0, 2) - 1);
    end
    if (r < 88) return $urandom_range(0, int'(b) * int'(b));
    if (r < 94) return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h8000_0000;
    return '0;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_value(input logic [IN_W-1:0] v, input bit predict,
                            input bit hold_after);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.value = v;
    do @(posedge clk); while (!in_if.ready);
    if (predict) predict_digits(v);
    if (hold_after) hold_req = 1'b1;
    @(negedge clk);
  endtask

  task automatic write_base(input logic [BASE_W-1:0] b);
    cfg_if.valid = 1'b1;
    cfg_if.data  = b;
    do @(posedge clk); while (!cfg_if.ready);
    cur_base = b;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Drain pending digits, then give a zero-value request time to retire.
  task automatic settle();
    in_if.valid = 1'b0;
    while (digits_q.size() != 0) @(negedge clk);
    repeat (DIGIT_CYCLES + 8) @(negedge clk);
  endtask

  function automatic void note_mismatch(input string what, input digit_rec_t want,
                                        input digit_rec_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("MISMATCH %s: expected digit=%0d char=%0d pos=%0d last=%0b, got digit=%0d char=%0d pos=%0d last=%0b",
               what, want.digit, want.digit_char, want.position, want.last,
               got.digit, got.digit_char, got.position, got.last);
  endfunction

  // Receiver: random gaps, plus one long hold-off on request.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req     = 1'b0;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (out_gap > 0) begin
        out_if.ready = 1'b0;
        out_gap--;
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    digit_rec_t got;
    digit_rec_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = digit_rec_t'{out_if.digit, out_if.digit_char, out_if.position, out_if.last};
      out_gap = pick_gap();
      if (digits_q.size() == 0) begin
        note_mismatch("unexpected digit", '0, got);
      end else begin
        want = digits_q.pop_front();
        if (got.digit !== want.digit || got.digit_char !== want.digit_char ||
            got.position !== want.position || got.last !== want.last)
          note_mismatch("digit fields", want, got);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    cur_base     = BASE_RESET;
    rst_n        = 1'b0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].base != cur_base) begin
        settle();
        write_base(dir_rows[i].base);
      end
      if (dir_rows[i].typed && dir_rows[i].n_digits != 0)
        digits_q.push_back(digit_rec_t'{dir_rows[i].digit, dir_rows[i].digit_char,
                                        POS_W'(0), 1'b1});
      send_value(dir_rows[i].value, !dir_rows[i].typed, 1'b0);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      settle();
      if (ph < 10) write_base(phase_bases[ph]);
      else write_base(BASE_W'($urandom_range(0, 63)));
      quiet = ($urandom_range(0, 3) == 0);
      // hold the receiver off once mid-phase while values keep coming
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_value(rand_value(), 1'b1, ph == 3 && n == 10);
    end

    settle();
    errors += digits_q.size();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
design/itd_pkg.sv
design/itd_if.sv
design/itd_div.sv
design/integer_to_radix_digits.sv
test/tb.sv
